// ===== hw/rtl/jsesc_pkg.sv =====
// ----------------------------------------------------------------------------
// jsesc_pkg
// Types, codes and constants shared by the JSON string escaper modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsesc_pkg;

  localparam int MAX_RESULTS = 15;
  localparam int COUNT_W     = 4;

  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_CLOSE = 2'd2
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]               count;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
  } res_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Three replacement characters, first byte in the lowest entry.
  localparam logic [8:0][7:0] REPL_SEQ = {
    REPL_B2, REPL_B1, REPL_B0,
    REPL_B2, REPL_B1, REPL_B0,
    REPL_B2, REPL_B1, REPL_B0
  };

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    case (nib)
      4'h0: d = 8'h30;
      4'h1: d = 8'h31;
      4'h2: d = 8'h32;
      4'h3: d = 8'h33;
      4'h4: d = 8'h34;
      4'h5: d = 8'h35;
      4'h6: d = 8'h36;
      4'h7: d = 8'h37;
      4'h8: d = 8'h38;
      4'h9: d = 8'h39;
      4'hA: d = 8'h61;
      4'hB: d = 8'h62;
      4'hC: d = 8'h63;
      4'hD: d = 8'h64;
      4'hE: d = 8'h65;
      default: d = 8'h66;
    endcase
    return d;
  endfunction

endpackage

// ===== hw/rtl/jsesc_encode.sv =====
// ----------------------------------------------------------------------------
// jsesc_encode
// UTF-8 hold state and the escape logic that turns one request into the
// full list of output bytes it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsesc_encode (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  jsesc_pkg::req_t   kind,
  input  logic [7:0]        data,
  output jsesc_pkg::res_t   res
);
  import jsesc_pkg::*;

  logic [2:0][7:0] held_bytes;
  logic [2:0][7:0] held_bytes_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic [1:0]      needed_count;
  logic [1:0]      needed_count_next;

  logic            hold_active;
  logic            cont_ok;
  logic [7:0]      lead;

  logic [15:0][7:0] seg_a;
  logic [3:0]       cnt_a;
  logic [15:0][7:0] seg_b;
  logic [2:0]       cnt_b;
  logic [3:0]       rel;

  assign lead        = held_bytes[0];
  assign hold_active = (held_count != 2'd0) && (needed_count != 2'd0);

  always_comb begin
    cont_ok = (data[7:6] == 2'b10);
    if (held_count == 2'd1) begin
      if ((lead == 8'hE0 && data < 8'hA0) || (lead == 8'hED && data > 8'h9F) ||
          (lead == 8'hF0 && data < 8'h90) || (lead == 8'hF4 && data > 8'h8F)) begin
        cont_ok = 1'b0;
      end
    end
  end

  always_comb begin
    logic fresh;
    logic flush;
    fresh             = 1'b0;
    flush             = 1'b0;
    seg_a             = '0;
    cnt_a             = '0;
    seg_b             = '0;
    cnt_b             = '0;
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    needed_count_next = needed_count;

    case (kind)
      REQ_OPEN: begin
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
        seg_b[0]          = CH_QUOTE;
        cnt_b             = 3'd1;
      end
      REQ_BYTE: begin
        if (hold_active && cont_ok) begin
          if (needed_count == 2'd1) begin
            for (int i = 0; i < 3; i++) begin
              seg_a[i] = (2'(i) < held_count) ? held_bytes[i] : data;
            end
            seg_a[3]          = data;
            cnt_a             = {2'b00, held_count} + 4'd1;
            held_count_next   = 2'd0;
            needed_count_next = 2'd0;
          end else if (held_count != 2'd3) begin
            held_bytes_next[held_count] = data;
            held_count_next             = held_count + 2'd1;
            needed_count_next           = needed_count - 2'd1;
          end
        end else begin
          flush = hold_active;
          fresh = 1'b1;
        end
      end
      REQ_CLOSE: begin
        flush             = 1'b1;
        held_count_next   = 2'd0;
        needed_count_next = 2'd0;
        seg_b[0]          = CH_QUOTE;
        cnt_b             = 3'd1;
      end
      default: begin
      end
    endcase

    if (flush) begin
      for (int i = 0; i < 9; i++) begin
        seg_a[i] = REPL_SEQ[i];
      end
      cnt_a = {2'b00, held_count} + {1'b0, held_count, 1'b0};
    end

    if (fresh) begin
      held_count_next   = 2'd0;
      needed_count_next = 2'd0;
      if (data == CH_QUOTE || data == CH_BSL) begin
        seg_b[0] = CH_BSL;
        seg_b[1] = data;
        cnt_b    = 3'd2;
      end else if (data < 8'h20) begin
        seg_b[0] = CH_BSL;
        cnt_b    = 3'd2;
        case (data)
          8'h0A: seg_b[1] = CH_N;
          8'h0D: seg_b[1] = CH_R;
          8'h09: seg_b[1] = CH_T;
          8'h08: seg_b[1] = CH_B;
          8'h0C: seg_b[1] = CH_F;
          default: begin
            seg_b[1] = CH_U;
            seg_b[2] = CH_ZERO;
            seg_b[3] = CH_ZERO;
            seg_b[4] = data[4] ? CH_ONE : CH_ZERO;
            seg_b[5] = hex_digit(data[3:0]);
            cnt_b    = 3'd6;
          end
        endcase
      end else if (data < 8'h80) begin
        seg_b[0] = data;
        cnt_b    = 3'd1;
      end else if (data >= 8'hC2 && data <= 8'hDF) begin
        held_bytes_next[0] = data;
        held_count_next    = 2'd1;
        needed_count_next  = 2'd1;
      end else if (data >= 8'hE0 && data <= 8'hEF) begin
        held_bytes_next[0] = data;
        held_count_next    = 2'd1;
        needed_count_next  = 2'd2;
      end else if (data >= 8'hF0 && data <= 8'hF4) begin
        held_bytes_next[0] = data;
        held_count_next    = 2'd1;
        needed_count_next  = 2'd3;
      end else begin
        seg_b[0] = REPL_B0;
        seg_b[1] = REPL_B1;
        seg_b[2] = REPL_B2;
        cnt_b    = 3'd3;
      end
    end
  end

  always_comb begin
    res.count = cnt_a + {1'b0, cnt_b};
    for (int i = 0; i < MAX_RESULTS; i++) begin
      rel          = 4'(i) - cnt_a;
      res.bytes[i] = (4'(i) < cnt_a) ? seg_a[i] : seg_b[rel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (take) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_bytes <= held_bytes_next;
    end
  end

endmodule

// ===== hw/rtl/jsesc_serial.sv =====
// ----------------------------------------------------------------------------
// jsesc_serial
// Result register that holds the bytes of one request and sends them out
// one beat per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsesc_serial (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  jsesc_pkg::res_t res,
  output logic            can_load,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,    // out_byte[7:0]
  output logic            m_tlast
);
  import jsesc_pkg::*;

  logic [MAX_RESULTS-1:0][7:0] bytes;
  logic [COUNT_W-1:0]          count;
  logic [COUNT_W-1:0]          idx;
  logic                        busy;
  logic                        is_last;
  logic                        send;

  assign is_last  = (idx == count - 4'd1);
  assign send     = busy && m_tready;
  assign can_load = !busy || (send && is_last);
  assign m_tvalid = busy;
  assign m_tdata  = bytes[idx];
  assign m_tlast  = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= (res.count != '0);
      idx  <= '0;
    end else if (send) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      count <= res.count;
    end
  end

endmodule

// ===== hw/rtl/json_string_escaper_utf8_repair_core.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_repair_core
// JSON string escaper with UTF-8 validation and repair.
// ----------------------------------------------------------------------------
// A request (open, string byte or close, kind on s_tuser) is taken and
// expanded at once into all of its output bytes, which a result register
// then sends out one beat per cycle while m_tready is high, with m_tlast on
// the final beat. A request yields between 1 and 15 output bytes, or none
// when its byte is held, which leaves the register free for the next request;
// otherwise the next request is taken in the same cycle as the last beat of
// the previous one, so plain ASCII flows at one byte per cycle while m_tready
// is high. Throughput is set by the one-byte output port.
`timescale 1ns / 1ps

module json_string_escaper_utf8_repair_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // data_byte[7:0]
  input  logic [1:0] s_tuser,     // req_type[1:0]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // out_byte[7:0]
  output logic       m_tlast      // last_of_run
);
  import jsesc_pkg::*;

  logic  take;
  logic  can_load;
  req_t  kind;
  res_t  res;

  assign kind     = req_t'(s_tuser);
  assign s_tready = can_load;
  assign take     = s_tvalid && can_load;

  jsesc_encode u_encode (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .kind (kind),
    .data (s_tdata),
    .res  (res)
  );

  jsesc_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take && res.count != '0 |=> m_tvalid)
    else $error("result bytes lost after a request");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("run ended before its last beat");

  a_no_take_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !(m_tready && m_tlast) |-> !s_tready)
    else $error("request taken while a run is still pending");

endmodule

// ===== tb/sv/json_string_escaper_utf8_repair_core_tb.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_utf8_repair_core_tb
// Self-checking testbench for the JSON string escaper with UTF-8 repair.
// ----------------------------------------------------------------------------
// Requests are offered on the slave stream and every accepted request is run
// through a behavioural escaper kept in the testbench. The bytes that it
// predicts are queued and compared, beat by beat, with the master stream.
// Directed tests cover the escapes and the UTF-8 repair cases. A back-pressure
// test fills the block while the output is held off. A long random run mixes
// well-formed strings with noise and broken sequences. Both sides idle at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_escaper_utf8_repair_core_tb;
  import jsesc_pkg::*;

  localparam logic [1:0] REQ_NONE     = 2'd3;
  localparam int         LIMIT_CYCLES = 500000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         RANDOM_ITEMS = 150;

  localparam logic [7:0] CTL_BS      = 8'h08;
  localparam logic [7:0] CTL_TAB     = 8'h09;
  localparam logic [7:0] CTL_LF      = 8'h0A;
  localparam logic [7:0] CTL_FF      = 8'h0C;
  localparam logic [7:0] CTL_CR      = 8'h0D;
  localparam logic [7:0] CTL_END     = 8'h20;
  localparam logic [7:0] ASCII_END   = 8'h80;
  localparam logic [7:0] ALPHA_BASE  = 8'h57;
  localparam logic [7:0] LEAD2_LO    = 8'hC2;
  localparam logic [7:0] LEAD2_HI    = 8'hDF;
  localparam logic [7:0] LEAD3_LO    = 8'hE0;
  localparam logic [7:0] LEAD3_SURR  = 8'hED;
  localparam logic [7:0] LEAD3_HI    = 8'hEF;
  localparam logic [7:0] LEAD4_LO    = 8'hF0;
  localparam logic [7:0] LEAD4_HI    = 8'hF4;
  localparam logic [7:0] CONT_LO     = 8'h80;
  localparam logic [7:0] CONT_HI     = 8'hBF;
  localparam logic [7:0] E0_CONT_LO  = 8'hA0;
  localparam logic [7:0] ED_CONT_HI  = 8'h9F;
  localparam logic [7:0] F0_CONT_LO  = 8'h90;
  localparam logic [7:0] F4_CONT_HI  = 8'h8F;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;      // data_byte[7:0]
  logic [1:0] s_tuser;      // req_type[1:0]
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;      // out_byte[7:0]
  logic       m_tlast;      // last_of_run

  out_beat_t  escaped_q[$];
  logic [7:0] run_q[$];
  logic [7:0] seq_held[3];
  logic [1:0] seq_count;
  logic [1:0] seq_need;

  int errors        = 0;
  int items_sent    = 0;
  int cycle_count   = 0;
  int rx_hold_cycles = 0;
  bit idle_en       = 1'b1;

  json_string_escaper_utf8_repair_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + 8'(nib) : ALPHA_BASE + 8'(nib);
  endfunction

  task automatic put_byte(input logic [7:0] b);
    run_q.push_back(b);
  endtask

  task automatic put_repl();
    put_byte(REPL_B0);
    put_byte(REPL_B1);
    put_byte(REPL_B2);
  endtask

  task automatic flush_held();
    for (int k = 0; k < seq_count; k++) put_repl();
    seq_count = 2'd0;
    seq_need  = 2'd0;
  endtask

  // Works out the output bytes of one accepted request and queues them.
  task automatic escape_item(input logic [1:0] kind, input logic [7:0] c);
    logic ok;
    logic fresh;
    run_q.delete();
    fresh = 1'b0;
    if (kind == REQ_OPEN) begin
      seq_count = 2'd0;
      seq_need  = 2'd0;
      put_byte(CH_QUOTE);
    end else if (kind == REQ_CLOSE) begin
      flush_held();
      put_byte(CH_QUOTE);
    end else if (kind == REQ_BYTE) begin
      fresh = 1'b1;
      if (seq_count != 2'd0) begin
        ok = (c[7:6] == 2'b10);
        if (seq_count == 2'd1) begin
          if (seq_held[0] == LEAD3_LO   && c < E0_CONT_LO) ok = 1'b0;
          if (seq_held[0] == LEAD3_SURR && c > ED_CONT_HI) ok = 1'b0;
          if (seq_held[0] == LEAD4_LO   && c < F0_CONT_LO) ok = 1'b0;
          if (seq_held[0] == LEAD4_HI   && c > F4_CONT_HI) ok = 1'b0;
        end
        if (ok) begin
          fresh = 1'b0;
          if (seq_need == 2'd1) begin
            for (int k = 0; k < seq_count; k++) put_byte(seq_held[k]);
            put_byte(c);
            seq_count = 2'd0;
            seq_need  = 2'd0;
          end else begin
            seq_held[seq_count] = c;
            seq_count++;
            seq_need--;
          end
        end else begin
          flush_held();
        end
      end
      if (fresh) begin
        if (c == CH_QUOTE || c == CH_BSL) begin
          put_byte(CH_BSL);
          put_byte(c);
        end else if (c < CTL_END) begin
          put_byte(CH_BSL);
          case (c)
            CTL_LF:  put_byte(CH_N);
            CTL_CR:  put_byte(CH_R);
            CTL_TAB: put_byte(CH_T);
            CTL_BS:  put_byte(CH_B);
            CTL_FF:  put_byte(CH_F);
            default: begin
              put_byte(CH_U);
              put_byte(CH_ZERO);
              put_byte(CH_ZERO);
              put_byte(hex_char(c[7:4]));
              put_byte(hex_char(c[3:0]));
            end
          endcase
        end else if (c < ASCII_END) begin
          put_byte(c);
        end else if (c >= LEAD2_LO && c <= LEAD2_HI) begin
          seq_held[0] = c;
          seq_count   = 2'd1;
          seq_need    = 2'd1;
        end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
          seq_held[0] = c;
          seq_count   = 2'd1;
          seq_need    = 2'd2;
        end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
          seq_held[0] = c;
          seq_count   = 2'd1;
          seq_need    = 2'd3;
        end else begin
          put_repl();
        end
      end
    end
    for (int i = 0; i < run_q.size(); i++) begin
      escaped_q.push_back('{data: run_q[i], last: (i == run_q.size() - 1)});
    end
  endtask

  // Offers one request; returns in the time step of the accepting edge.
  task automatic offer_req(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    gap = idle_en ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    escape_item(kind, b);
    if (kind != REQ_NONE) items_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_valid_char();
    logic [7:0] lead;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: offer_req(REQ_BYTE, 8'($urandom_range(32, 126)));
      4:          offer_req(REQ_BYTE, 8'($urandom_range(0, 31)));
      5: begin
        offer_req(REQ_BYTE, 8'($urandom_range(LEAD2_LO, LEAD2_HI)));
        offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
      end
      6, 7: begin
        lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
        offer_req(REQ_BYTE, lead);
        if (lead == LEAD3_LO)
          offer_req(REQ_BYTE, 8'($urandom_range(E0_CONT_LO, CONT_HI)));
        else if (lead == LEAD3_SURR)
          offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, ED_CONT_HI)));
        else
          offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
        offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
      end
      8: begin
        lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
        offer_req(REQ_BYTE, lead);
        if (lead == LEAD4_LO)
          offer_req(REQ_BYTE, 8'($urandom_range(F0_CONT_LO, CONT_HI)));
        else if (lead == LEAD4_HI)
          offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, F4_CONT_HI)));
        else
          offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
        offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
        offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
      end
      default: offer_req(REQ_BYTE, ($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_BSL);
    endcase
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: offer_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      1: offer_req(REQ_BYTE, 8'($urandom_range(0, 255)));
      2: begin
        offer_req(REQ_BYTE, 8'($urandom_range(LEAD2_LO, LEAD4_HI)));
        offer_req(REQ_BYTE, 8'($urandom_range(0, 255)));
      end
      default: begin
        offer_req(REQ_BYTE, 8'($urandom_range(LEAD3_LO, LEAD4_HI)));
        if ($urandom_range(0, 1) != 0)
          offer_req(REQ_BYTE, 8'($urandom_range(CONT_LO, CONT_HI)));
        offer_req(($urandom_range(0, 1) != 0) ? REQ_CLOSE : REQ_OPEN,
                  8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_escapes();
    offer_req(REQ_OPEN, 8'hFF);
    offer_req(REQ_BYTE, 8'h00);
    offer_req(REQ_BYTE, CTL_LF);
    offer_req(REQ_BYTE, CTL_CR);
    offer_req(REQ_BYTE, CTL_TAB);
    offer_req(REQ_BYTE, CTL_BS);
    offer_req(REQ_BYTE, CTL_FF);
    offer_req(REQ_BYTE, CH_QUOTE);
    offer_req(REQ_BYTE, CH_BSL);
    offer_req(REQ_BYTE, 8'h7F);
    offer_req(REQ_NONE, 8'h41);
  endtask

  task automatic test_utf8_repair();
    offer_req(REQ_BYTE, 8'hF4);
    offer_req(REQ_BYTE, 8'h8F);
    offer_req(REQ_BYTE, 8'hBF);
    offer_req(REQ_BYTE, 8'hBF);
    offer_req(REQ_BYTE, 8'hE0);
    offer_req(REQ_BYTE, 8'h80);
    offer_req(REQ_BYTE, 8'hFF);
    offer_req(REQ_BYTE, 8'hF0);
    offer_req(REQ_BYTE, 8'h90);
    offer_req(REQ_CLOSE, 8'hFF);
    offer_req(REQ_BYTE, 8'h41);
    offer_req(REQ_BYTE, 8'hE2);
    offer_req(REQ_OPEN, 8'h00);
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    rx_hold_cycles = 300;
    repeat (24) offer_req(REQ_BYTE, 8'($urandom_range(0, 31)));
    offer_req(REQ_CLOSE, 8'h00);
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random();
    int stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) begin
        offer_req(REQ_OPEN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 8)) send_valid_char();
        offer_req(REQ_CLOSE, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    idle_en = 1'b1;
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= 8'h00;
    s_tuser  <= REQ_OPEN;
    seq_count = 2'd0;
    seq_need  = 2'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_escapes();
    test_utf8_repair();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : rx_side
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = idle_en ? $urandom_range(0, 13) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_beats
    out_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (escaped_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual out_byte %h last %b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = escaped_q.pop_front();
        if (m_tdata !== want.data) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, m_tdata);
        end
        if (m_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_run mismatch: expected %b, actual %b",
                   $time, want.last, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule
